// ===== src/isr_pkg.sv =====
// isr_pkg: widths, limits and pipeline stage records for importance_split_roulette.
// No dependencies; imported by the top level and the port checker.
package isr_pkg;

  localparam int unsigned WeightW   = 32;
  localparam int unsigned ImpW      = 16;
  localparam int unsigned FracW     = 16;
  localparam int unsigned CopyW     = 6;
  localparam int unsigned MaxSplit  = 64;
  localparam int unsigned SplitW    = $clog2(MaxSplit + 1);
  localparam int unsigned Div1Steps = ImpW;
  localparam int unsigned Div2Steps = WeightW;
  // input register + ratio divider + decide + weight divider + output register
  localparam int unsigned Latency   = Div1Steps + Div2Steps + 3;

  localparam logic [WeightW-1:0] WeightMax = '1;

  // Ratio divider stage: quo shifts I2 out and the quotient in.
  typedef struct packed {
    logic [WeightW-1:0]      w;
    logic [ImpW-1:0]         i1;
    logic [ImpW-1:0]         i2;
    logic [FracW-1:0]        r;
    logic [WeightW+ImpW-1:0] pw;   // weight * I1
    logic [FracW+ImpW-1:0]   pr;   // r * I1
    logic [ImpW-1:0]         rem;
    logic [ImpW-1:0]         quo;
  } d1_stage_t;

  // Weight divider stage: lo shifts the dividend out and the quotient in.
  typedef struct packed {
    logic [ImpW-1:0]    rem;
    logic [WeightW-1:0] lo;
    logic [ImpW-1:0]    dvsr;
    logic               use_div;
    logic               killed;
    logic [CopyW-1:0]   copies;
    logic               sat;
  } d2_stage_t;

endpackage

// ===== src/importance_split_roulette.sv =====
// importance_split_roulette: splitting / Russian roulette pipeline, one particle per clock.
// Depends on isr_pkg.
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+-------------------------------
//  input    | in_weight, in_importance_from/to,             | taken at edge with start && !busy
//           | in_random_fraction                            |
//  result   | out_new_weight, out_killed, out_copy_count,   | out_valid for one cycle, no
//           | out_saturated                                 | back-pressure
//
// One transaction enters per clock and passes the input register, ratio divider, decide
// register, weight divider and output register; it is taken when its out_valid cycle ends.
// Latency is set by the two bit-serial restoring dividers: 16 stages for I2/I1 and
// 32 stages for the weight quotient, plus input, decide and output registers.
// busy is high only during reset; the pipeline never stalls since the receiver cannot.
// Synchronous reset clears valid bits only; in-flight transactions are dropped.
module importance_split_roulette (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [isr_pkg::WeightW-1:0] in_weight,
  input  logic [isr_pkg::ImpW-1:0]    in_importance_from,
  input  logic [isr_pkg::ImpW-1:0]    in_importance_to,
  input  logic [isr_pkg::FracW-1:0]   in_random_fraction,
  output logic                        out_valid,
  output logic [isr_pkg::WeightW-1:0] out_new_weight,
  output logic                        out_killed,
  output logic [isr_pkg::CopyW-1:0]   out_copy_count,
  output logic                        out_saturated
);
  import isr_pkg::*;

  d1_stage_t d1_r   [Div1Steps+1];
  logic      d1_v_r [Div1Steps+1];
  d2_stage_t d2_r   [Div2Steps+1];
  logic      d2_v_r [Div2Steps+1];
  d2_stage_t dec_nxt;

  logic               out_valid_r;
  logic [WeightW-1:0] out_w_r;
  logic               out_k_r;
  logic [CopyW-1:0]   out_c_r;
  logic               out_s_r;

  assign busy = ~rst_n;

  // Input register; the ratio dividend (I2) starts in quo.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r[0] <= 1'b0;
    end else begin
      d1_v_r[0] <= start;
    end
    d1_r[0].w   <= in_weight;
    d1_r[0].i1  <= in_importance_from;
    d1_r[0].i2  <= in_importance_to;
    d1_r[0].r   <= in_random_fraction;
    d1_r[0].pw  <= '0;
    d1_r[0].pr  <= '0;
    d1_r[0].rem <= '0;
    d1_r[0].quo <= in_importance_to;
  end

  // Ratio divider: q = I2 / I1, one quotient bit per stage.
  // Both products are taken in the first stage and ride along.
  for (genvar k = 1; k <= Div1Steps; k++) begin : g_d1
    d1_stage_t     d1_nxt;
    logic [ImpW:0] rem2;
    logic          ge;

    always_comb begin
      d1_nxt = d1_r[k-1];
      rem2   = {d1_r[k-1].rem, d1_r[k-1].quo[ImpW-1]};
      ge     = rem2 >= {1'b0, d1_r[k-1].i1};
      d1_nxt.rem = ge ? ImpW'(rem2 - {1'b0, d1_r[k-1].i1}) : rem2[ImpW-1:0];
      d1_nxt.quo = {d1_r[k-1].quo[ImpW-2:0], ge};
      if (k == 1) begin
        d1_nxt.pw = (WeightW+ImpW)'(d1_r[k-1].w) * (WeightW+ImpW)'(d1_r[k-1].i1);
        d1_nxt.pr = (FracW+ImpW)'(d1_r[k-1].r) * (FracW+ImpW)'(d1_r[k-1].i1);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_v_r[k] <= 1'b0;
      end else begin
        d1_v_r[k] <= d1_v_r[k-1];
      end
      d1_r[k] <= d1_nxt;
    end
  end

  // Decide: kill, split, roulette or pass; set up the weight divider.
  // Split count n = q + carry, carry = (rem*2^16 + r*I1 >= I1*2^16).
  always_comb begin
    d1_stage_t           s;
    logic [ImpW+16:0]    tsum;
    logic                rbit;
    logic [ImpW:0]       n;
    logic [SplitW-1:0]   nsp;

    s    = d1_r[Div1Steps];
    tsum = {1'b0, s.rem, 16'b0} + (ImpW+17)'(s.pr);
    rbit = tsum >= {1'b0, s.i1, 16'b0};
    n    = {1'b0, s.quo} + (ImpW+1)'(rbit);
    nsp  = SplitW'(MaxSplit);

    dec_nxt.rem     = '0;
    dec_nxt.lo      = s.w;
    dec_nxt.dvsr    = ImpW'(1);
    dec_nxt.use_div = 1'b0;
    dec_nxt.killed  = 1'b0;
    dec_nxt.copies  = '0;
    dec_nxt.sat     = 1'b0;

    priority if (s.i2 == '0) begin
      dec_nxt.killed = 1'b1;
      dec_nxt.lo     = '0;
    end else if (s.i2 > s.i1) begin
      if (s.i1 == '0 || n > (ImpW+1)'(MaxSplit)) begin
        nsp         = SplitW'(MaxSplit);
        dec_nxt.sat = 1'b1;
      end else begin
        nsp = n[SplitW-1:0];
      end
      if (nsp > SplitW'(1)) begin
        dec_nxt.use_div = 1'b1;
        dec_nxt.dvsr    = ImpW'(nsp);
        dec_nxt.copies  = CopyW'(nsp - SplitW'(1));
      end
    end else if (s.i2 < s.i1) begin
      if (s.pr < {s.i2, 16'b0}) begin
        // survivor: weight*I1/I2, clamp when the quotient needs more than 32 bits
        if (s.pw[WeightW+ImpW-1:WeightW] >= s.i2) begin
          dec_nxt.lo  = WeightMax;
          dec_nxt.sat = 1'b1;
        end else begin
          dec_nxt.use_div = 1'b1;
          dec_nxt.rem     = s.pw[WeightW+ImpW-1:WeightW];
          dec_nxt.lo      = s.pw[WeightW-1:0];
          dec_nxt.dvsr    = s.i2;
        end
      end else begin
        dec_nxt.killed = 1'b1;
        dec_nxt.lo     = '0;
      end
    end else begin
      dec_nxt.lo = s.w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_v_r[0] <= 1'b0;
    end else begin
      d2_v_r[0] <= d1_v_r[Div1Steps];
    end
    d2_r[0] <= dec_nxt;
  end

  // Weight divider: 48/16 restoring division, one quotient bit per stage.
  // Entries with use_div low just ride through; lo already holds the weight.
  for (genvar k = 1; k <= Div2Steps; k++) begin : g_d2
    d2_stage_t     d2_nxt;
    logic [ImpW:0] rem2;
    logic          ge;

    always_comb begin
      d2_nxt = d2_r[k-1];
      rem2   = {d2_r[k-1].rem, d2_r[k-1].lo[WeightW-1]};
      ge     = rem2 >= {1'b0, d2_r[k-1].dvsr};
      if (d2_r[k-1].use_div) begin
        d2_nxt.rem = ge ? ImpW'(rem2 - {1'b0, d2_r[k-1].dvsr}) : rem2[ImpW-1:0];
        d2_nxt.lo  = {d2_r[k-1].lo[WeightW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d2_v_r[k] <= 1'b0;
      end else begin
        d2_v_r[k] <= d2_v_r[k-1];
      end
      d2_r[k] <= d2_nxt;
    end
  end

  // Output register: one-cycle result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d2_v_r[Div2Steps];
    end
    out_w_r <= d2_r[Div2Steps].lo;
    out_k_r <= d2_r[Div2Steps].killed;
    out_c_r <= d2_r[Div2Steps].copies;
    out_s_r <= d2_r[Div2Steps].sat;
  end

  assign out_valid      = out_valid_r;
  assign out_new_weight = out_w_r;
  assign out_killed     = out_k_r;
  assign out_copy_count = out_c_r;
  assign out_saturated  = out_s_r;

endmodule

// ===== src/isr_checker.sv =====
// isr_checker: port-level assertions for importance_split_roulette, plus its bind.
// Depends on isr_pkg.
module isr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [isr_pkg::WeightW-1:0] in_weight,
  input logic [isr_pkg::ImpW-1:0]    in_importance_from,
  input logic [isr_pkg::ImpW-1:0]    in_importance_to,
  input logic [isr_pkg::FracW-1:0]   in_random_fraction,
  input logic                        out_valid,
  input logic [isr_pkg::WeightW-1:0] out_new_weight,
  input logic                        out_killed,
  input logic [isr_pkg::CopyW-1:0]   out_copy_count,
  input logic                        out_saturated
);
  import isr_pkg::*;

  // every result traces back to a transaction taken earlier at the input
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, Latency))
    else $error("result without matching transaction");

  a_kill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_killed) |-> (out_new_weight == '0 && out_copy_count == '0
                                   && !out_saturated))
    else $error("killed particle carries weight or copies");

  a_copies: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_copy_count != '0) |->
      (out_copy_count <= CopyW'(MaxSplit - 1)))
    else $error("copy count above split limit");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated && out_copy_count == '0) |->
      (out_new_weight == WeightMax))
    else $error("saturated survivor not clamped");

  // busy follows reset and nothing else
  a_never_busy: assert property (@(posedge clk)
    busy == !rst_n)
    else $error("busy outside reset");

endmodule

bind importance_split_roulette isr_checker u_isr_checker (.*);

// ===== bench/isr_checker.sv =====
// isr_scoreboard: watches the particle and result channels of importance_split_roulette,
// predicts each result and compares it. Depends on isr_pkg.
`timescale 1ns / 100ps

module isr_scoreboard (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [isr_pkg::WeightW-1:0] in_weight,
  input  logic [isr_pkg::ImpW-1:0]    in_importance_from,
  input  logic [isr_pkg::ImpW-1:0]    in_importance_to,
  input  logic [isr_pkg::FracW-1:0]   in_random_fraction,
  input  logic                        out_valid,
  input  logic [isr_pkg::WeightW-1:0] out_new_weight,
  input  logic                        out_killed,
  input  logic [isr_pkg::CopyW-1:0]   out_copy_count,
  input  logic                        out_saturated,
  output int                          fail_count,
  output int                          pending
);
  import isr_pkg::*;

  typedef struct packed {
    logic [WeightW-1:0] w;
    logic               killed;
    logic [CopyW-1:0]   copies;
    logic               sat;
  } particle_fate_t;

  particle_fate_t fate_q[$];

  function automatic particle_fate_t fate_of(logic [WeightW-1:0] w, logic [ImpW-1:0] i1,
                                             logic [ImpW-1:0] i2, logic [FracW-1:0] r);
    particle_fate_t f;
    logic [63:0] n, num, den, nw;
    f = '{w: w, killed: 1'b0, copies: '0, sat: 1'b0};
    if (i2 == 0) begin
      f.killed = 1'b1;
      f.w = '0;
    end else if (i2 > i1) begin
      if (i1 == 0) begin
        n = 64'(MaxSplit);
        f.sat = 1'b1;
      end else begin
        num = ({48'd0, i2} << 16) + 64'(r) * 64'(i1);
        den = {48'd0, i1} << 16;
        n = num / den;
        if (n > 64'(MaxSplit)) begin
          n = 64'(MaxSplit);
          f.sat = 1'b1;
        end
      end
      if (n > 1) begin
        f.w = WeightW'(64'(w) / n);
        f.copies = CopyW'(n - 1);
      end
    end else if (i2 < i1) begin
      // roulette: survive when u < I2/I1, exact cross product
      if (64'(r) * 64'(i1) < ({48'd0, i2} << 16)) begin
        nw = (64'(w) * 64'(i1)) / 64'(i2);
        if (nw > 64'(WeightMax)) begin
          nw = 64'(WeightMax);
          f.sat = 1'b1;
        end
        f.w = nw[WeightW-1:0];
      end else begin
        f.killed = 1'b1;
        f.w = '0;
      end
    end
    return f;
  endfunction

  always @(posedge clk) begin
    particle_fate_t e;
    if (!rst_n) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (start && !busy)
        fate_q.push_back(fate_of(in_weight, in_importance_from, in_importance_to,
                                 in_random_fraction));
      if (out_valid) begin
        if (fate_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result w=%h", out_new_weight);
          fail_count <= fail_count + 1;
        end else begin
          e = fate_q.pop_front();
          if (e.w !== out_new_weight || e.killed !== out_killed ||
              e.copies !== out_copy_count || e.sat !== out_saturated) begin
            if (fail_count < 10)
              $display("mismatch: exp w=%h k=%b c=%0d s=%b got w=%h k=%b c=%0d s=%b",
                       e.w, e.killed, e.copies, e.sat, out_new_weight, out_killed,
                       out_copy_count, out_saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= fate_q.size();
    end
  end
endmodule

// ===== bench/testbench.sv =====
// testbench: stimulus and verdict for importance_split_roulette.
// Depends on isr_pkg, isr_scoreboard and the block itself.
`timescale 1ns / 100ps

module testbench;
  import isr_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [WeightW-1:0] in_weight = '0;
  logic [ImpW-1:0]    in_importance_from = '0;
  logic [ImpW-1:0]    in_importance_to = '0;
  logic [FracW-1:0]   in_random_fraction = '0;
  logic               out_valid;
  logic [WeightW-1:0] out_new_weight;
  logic               out_killed;
  logic [CopyW-1:0]   out_copy_count;
  logic               out_saturated;
  int                 fail_count, pending;
  int                 cycle_count = 0;

  always #5 clk = ~clk;

  importance_split_roulette DUT (.*);

  isr_scoreboard checker_i (.*);

  // generous ceiling: every transaction with a long gap plus drain
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("** importance_split_roulette: FAILED **");
      $finish;
    end
  end

  // Present one transaction and hold it until the block takes it.
  task automatic send_particle(logic [WeightW-1:0] w, logic [ImpW-1:0] i1,
                               logic [ImpW-1:0] i2, logic [FracW-1:0] r);
    start              <= 1'b1;
    in_weight          <= w;
    in_importance_from <= i1;
    in_importance_to   <= i2;
    in_random_fraction <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Mostly back to back, some short gaps, rare long ones.
  task automatic idle_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return;
    start <= 1'b0;
    if (k < 93) repeat ($urandom_range(1, 3)) @(posedge clk);
    else repeat ($urandom_range(10, 70)) @(posedge clk);
  endtask

  function automatic logic [ImpW-1:0] rand_imp();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return '0;
    if (k == 1) return '1;
    if (k < 6) return ImpW'($urandom_range(1, 1024));   // near unity, Q8.8
    return ImpW'($urandom);
  endfunction

  initial begin
    logic [ImpW-1:0] a, b;
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes and each special case
    send_particle('1, 16'h0100, 16'h0000, 16'h1234);    // zero destination
    send_particle('1, 16'h0000, 16'h0100, 16'h0000);    // zero source, infinite ratio
    send_particle('1, 16'h0001, 16'hFFFF, 16'hFFFF);    // split count clamped
    send_particle(32'h0001_0000, 16'h0100, 16'h0200, 16'h0000); // split by two
    send_particle(32'h0001_0000, 16'h0100, 16'h0180, 16'h7FFF); // n of one, unchanged
    send_particle(32'h0001_0000, 16'h0100, 16'h0180, 16'h8000); // n of two
    send_particle(32'h1234_5678, 16'h0300, 16'h0300, 16'hFFFF); // equal importances
    send_particle('1, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_particle(32'h0001_0000, 16'h0200, 16'h0100, 16'h0000); // roulette survive
    send_particle(32'h0001_0000, 16'h0200, 16'h0100, 16'h8000); // roulette kill at edge
    send_particle(32'h0001_0000, 16'h0200, 16'h0100, 16'h7FFF); // just survives
    send_particle('1, 16'hFFFF, 16'h0001, 16'h0000);    // roulette weight clamps
    send_particle('0, 16'hFFFF, 16'h0001, 16'h0000);
    send_particle('1, 16'h0001, 16'h0002, 16'hFFFF);
    send_particle(32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_particle(32'h5555_5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_particle('0, 16'h0000, 16'h0000, 16'h0000);    // both zero: killed

    for (int i = 0; i < 1250; i++) begin
      a = rand_imp();
      b = rand_imp();
      k = $urandom_range(0, 9);
      if (k == 0) b = a;
      else if (k < 3 && a != 0) b = ImpW'(a + $urandom_range(0, 3)); // n near one
      send_particle($urandom_range(0, 3) == 0 ? WeightW'($urandom_range(0, 3)) :
                    WeightW'($urandom), a, b, FracW'($urandom));
      idle_gap();
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** importance_split_roulette: PASSED **");
    end else begin
      $display("** importance_split_roulette: FAILED **");
    end
    $finish;
  end
endmodule
